[rtl/gbcc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gbcc_pkg
// types and fixed constants of the gyro bias calibration and correction block
// ---------------------------------------------------------------------------
package gbcc_pkg;

	localparam int unsigned DAT_W    = 16;  // one sample field
	localparam int unsigned SUM_W    = 32;  // per-axis accumulator
	localparam int unsigned CNT_W    = 16;  // per-axis accepted count
	localparam int unsigned ADD_W    = 33;  // shared adder width
	localparam int unsigned MAG_W    = 31;  // magnitude of a sum
	localparam int unsigned STEP_W   = 5;   // divide step counter
	localparam int unsigned NUM_IO   = 3;   // axes carried on the ports
	localparam int unsigned LIM_W    = 15;  // bias_limit width
	localparam int unsigned IDX_W    = 1;   // register index width

	localparam logic [CNT_W-1:0]  CAL_SAMPLES_RST = 16'd200;
	localparam logic [LIM_W-1:0]  BIAS_LIMIT_RST  = 15'd2620;
	localparam logic [CNT_W-1:0]  CNT_MAX         = 16'hFFFF;
	localparam logic [STEP_W-1:0] DIV_LAST_STEP   = 5'd30;

	localparam logic [IDX_W-1:0] REG_CAL_SAMPLES = 1'b0;
	localparam logic [IDX_W-1:0] REG_BIAS_LIMIT  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAL_AXIS,
		ST_CAL_END,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_SIGN,
		ST_RUN_AXIS,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		ADD_NONE,
		ADD_ACC,
		ADD_DIV,
		ADD_NEG,
		ADD_CORR
	} add_sel_t;

endpackage

`default_nettype wire

[rtl/gyro_bias_calibrate_correct.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gyro_bias_calibrate_correct
// gyro zero-rate bias calibration over a sample window, then bias correction
// ---------------------------------------------------------------------------
// calibration request: an accept, one accumulate state per axis (AXES), then a window check
//   the request that closes the window adds, per axis, a load, 31 restoring
//   divide steps and a sign fix through the one shared adder, or only the
//   load for an axis that accepted nothing
// corrected request: accept, 3 axis steps, output load; a new request is taken
//   only back in idle, after the output load; the adder is shared across axes
// arst_n clears window, sums, counts, offsets and held values at once

module gyro_bias_calibrate_correct #(
	parameter int unsigned AXES = 3
) (
	input  wire          clk,
	input  wire          arst_n,
	// configuration write channel
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [0:0]   cfg_index,
	input  wire  [15:0]  cfg_data,
	// sample requests
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [95:0]  s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  wire  [0:0]   s_tuser,   // read_ok
	// corrected results
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [143:0] m_tdata,   // acc_x_out, acc_y_out, acc_z_out, rate_x_out,
	                                // rate_y_out, rate_z_out, bias_x, bias_y, bias_z
	output logic [0:0]   m_tuser    // stale
);

	localparam int unsigned AXW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int unsigned DW  = gbcc_pkg::DAT_W;
	localparam int unsigned AW  = gbcc_pkg::ADD_W;

	// configuration registers
	logic [gbcc_pkg::CNT_W-1:0] cal_samples_q;
	logic [gbcc_pkg::LIM_W-1:0] bias_limit_q;

	// sequencer
	gbcc_pkg::state_t   state_q, state_nxt;
	gbcc_pkg::add_sel_t add_sel;
	logic [1:0]         axis_q;
	logic               calibrating_q;
	logic [gbcc_pkg::CNT_W-1:0] window_q;

	// captured request
	logic [95:0] data_q;
	logic        ok_q;

	// calibration state
	logic signed [gbcc_pkg::SUM_W-1:0] sum_q [AXES];
	logic [gbcc_pkg::CNT_W-1:0]        cnt_q [AXES];
	logic [DW-1:0]                     offset_q [gbcc_pkg::NUM_IO];

	// divider state
	logic [gbcc_pkg::MAG_W-1:0]  mag_q;
	logic [DW-1:0]               rem_q;
	logic                        neg_q;
	logic [gbcc_pkg::STEP_W-1:0] step_q;

	// held outputs
	logic [DW-1:0] last_accel_q [gbcc_pkg::NUM_IO];
	logic [DW-1:0] last_rate_q  [gbcc_pkg::NUM_IO];

	// output register
	logic          m_valid_q;
	logic [143:0]  m_data_q;
	logic          m_stale_q;

	// per-axis views of the captured request
	logic signed [DW-1:0] accel_in [gbcc_pkg::NUM_IO];
	logic signed [DW-1:0] gyro_in  [gbcc_pkg::NUM_IO];

	always_comb begin
		for (int i = 0; i < int'(gbcc_pkg::NUM_IO); i++) begin
			accel_in[i] = data_q[i*DW +: DW];
			gyro_in[i]  = data_q[(i+3)*DW +: DW];
		end
	end

	// current axis selections
	logic [AXW-1:0]                    cax;
	logic signed [DW-1:0]              g_cur;
	logic signed [gbcc_pkg::SUM_W-1:0] sum_cur;
	logic [gbcc_pkg::CNT_W-1:0]        cnt_cur;
	logic                              axis_last_cal;
	logic                              axis_last_io;
	logic                              in_range;
	logic [DW:0]                       trial;

	assign cax           = axis_q[AXW-1:0];
	assign g_cur         = gyro_in[axis_q];
	assign sum_cur       = sum_q[cax];
	assign cnt_cur       = cnt_q[cax];
	assign axis_last_cal = (axis_q == 2'(AXES - 1));
	assign axis_last_io  = (axis_q == 2'(gbcc_pkg::NUM_IO - 1));
	assign trial         = {rem_q, mag_q[gbcc_pkg::MAG_W-1]};

	// strictly inside plus or minus bias_limit
	always_comb begin
		logic signed [DW:0] g_ext;
		logic signed [DW:0] lim_ext;
		g_ext    = {g_cur[DW-1], g_cur};
		lim_ext  = {2'b00, bias_limit_q};
		in_range = (g_ext < lim_ext) && (g_ext > -lim_ext);
	end

	// shared adder: accumulate, divide trial, negate, bias subtract
	logic [AW-1:0] add_a, add_b, add_res;
	logic          add_sub;

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (add_sel)
			gbcc_pkg::ADD_ACC: begin
				add_a = AW'(sum_cur);
				add_b = AW'(g_cur);
			end
			gbcc_pkg::ADD_DIV: begin
				add_a   = AW'(trial);
				add_b   = AW'(cnt_cur);
				add_sub = 1'b1;
			end
			gbcc_pkg::ADD_NEG: begin
				// load step negates the sum, sign step negates the quotient
				add_b   = (state_q == gbcc_pkg::ST_DIV_LOAD) ? AW'(sum_cur)
				                                            : AW'(mag_q);
				add_sub = 1'b1;
			end
			gbcc_pkg::ADD_CORR: begin
				add_a   = AW'(gyro_in[axis_q]);
				add_b   = AW'(offset_q[axis_q]);
				add_sub = 1'b1;
			end
			default: ;
		endcase
		add_res = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
	end

	logic div_fits;
	assign div_fits = ~add_res[AW-1];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gbcc_pkg::ST_IDLE:
				if (s_tvalid) state_nxt = calibrating_q ? gbcc_pkg::ST_CAL_AXIS
				                                        : gbcc_pkg::ST_RUN_AXIS;
			gbcc_pkg::ST_CAL_AXIS:
				if (axis_last_cal) state_nxt = gbcc_pkg::ST_CAL_END;
			gbcc_pkg::ST_CAL_END:
				state_nxt = (window_q >= cal_samples_q) ? gbcc_pkg::ST_DIV_LOAD
				                                       : gbcc_pkg::ST_IDLE;
			gbcc_pkg::ST_DIV_LOAD:
				if (cnt_cur == '0) begin
					state_nxt = axis_last_cal ? gbcc_pkg::ST_IDLE : gbcc_pkg::ST_DIV_LOAD;
				end else begin
					state_nxt = gbcc_pkg::ST_DIV_STEP;
				end
			gbcc_pkg::ST_DIV_STEP:
				if (step_q == '0) state_nxt = gbcc_pkg::ST_DIV_SIGN;
			gbcc_pkg::ST_DIV_SIGN:
				state_nxt = axis_last_cal ? gbcc_pkg::ST_IDLE : gbcc_pkg::ST_DIV_LOAD;
			gbcc_pkg::ST_RUN_AXIS:
				if (axis_last_io) state_nxt = gbcc_pkg::ST_OUT;
			gbcc_pkg::ST_OUT:
				if (!m_valid_q || m_tready) state_nxt = gbcc_pkg::ST_IDLE;
			default:
				state_nxt = gbcc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		add_sel  = gbcc_pkg::ADD_NONE;
		unique case (state_q)
			gbcc_pkg::ST_IDLE:     s_tready = 1'b1;
			gbcc_pkg::ST_CAL_AXIS: add_sel  = gbcc_pkg::ADD_ACC;
			gbcc_pkg::ST_DIV_LOAD: add_sel  = gbcc_pkg::ADD_NEG;
			gbcc_pkg::ST_DIV_STEP: add_sel  = gbcc_pkg::ADD_DIV;
			gbcc_pkg::ST_DIV_SIGN: add_sel  = gbcc_pkg::ADD_NEG;
			gbcc_pkg::ST_RUN_AXIS: add_sel  = gbcc_pkg::ADD_CORR;
			default: ;
		endcase
	end

	// writes are taken in any state; software is to write only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q <= gbcc_pkg::CAL_SAMPLES_RST;
			bias_limit_q  <= gbcc_pkg::BIAS_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gbcc_pkg::REG_CAL_SAMPLES: cal_samples_q <= cfg_data;
				gbcc_pkg::REG_BIAS_LIMIT:  bias_limit_q  <= cfg_data[gbcc_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// captured request, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_q <= s_tdata;
			ok_q   <= s_tuser[0];
		end
	end

	// sequencer, calibration and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gbcc_pkg::ST_IDLE;
			axis_q        <= '0;
			calibrating_q <= 1'b1;
			window_q      <= '0;
			mag_q         <= '0;
			rem_q         <= '0;
			neg_q         <= 1'b0;
			step_q        <= '0;
			for (int i = 0; i < int'(AXES); i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			for (int i = 0; i < int'(gbcc_pkg::NUM_IO); i++) begin
				offset_q[i]     <= '0;
				last_accel_q[i] <= '0;
				last_rate_q[i]  <= '0;
			end
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				gbcc_pkg::ST_IDLE: begin
					axis_q <= '0;
					if (s_tvalid && calibrating_q && window_q != gbcc_pkg::CNT_MAX)
						window_q <= window_q + 1'b1;
				end
				gbcc_pkg::ST_CAL_AXIS: begin
					if (ok_q && in_range) begin
						sum_q[cax] <= add_res[gbcc_pkg::SUM_W-1:0];
						if (cnt_cur != gbcc_pkg::CNT_MAX) cnt_q[cax] <= cnt_cur + 1'b1;
					end
					axis_q <= axis_q + 1'b1;
				end
				gbcc_pkg::ST_CAL_END:
					axis_q <= '0;
				gbcc_pkg::ST_DIV_LOAD: begin
					// magnitude of the sum, quotient bits shift in from below
					neg_q  <= sum_cur[gbcc_pkg::SUM_W-1];
					mag_q  <= sum_cur[gbcc_pkg::SUM_W-1] ? add_res[gbcc_pkg::MAG_W-1:0]
					                                     : sum_cur[gbcc_pkg::MAG_W-1:0];
					rem_q  <= '0;
					step_q <= gbcc_pkg::DIV_LAST_STEP;
					if (cnt_cur == '0) begin
						offset_q[axis_q] <= '0;
						axis_q           <= axis_q + 1'b1;
						if (axis_last_cal) calibrating_q <= 1'b0;
					end
				end
				gbcc_pkg::ST_DIV_STEP: begin
					rem_q  <= div_fits ? add_res[DW-1:0] : trial[DW-1:0];
					mag_q  <= {mag_q[gbcc_pkg::MAG_W-2:0], div_fits};
					step_q <= step_q - 1'b1;
				end
				gbcc_pkg::ST_DIV_SIGN: begin
					// truncation toward zero: negate the magnitude quotient for a negative sum
					offset_q[axis_q] <= neg_q ? add_res[DW-1:0] : mag_q[DW-1:0];
					axis_q           <= axis_q + 1'b1;
					if (axis_last_cal) calibrating_q <= 1'b0;
				end
				gbcc_pkg::ST_RUN_AXIS: begin
					if (ok_q) begin
						last_accel_q[axis_q] <= accel_in[axis_q];
						last_rate_q[axis_q]  <= add_res[DW-1:0];
					end
					axis_q <= axis_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// output register, frees the sequencer while a result waits
	logic out_load;
	assign out_load = (state_q == gbcc_pkg::ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < int'(gbcc_pkg::NUM_IO); i++) begin
				m_data_q[i*DW +: DW]     <= last_accel_q[i];
				m_data_q[(i+3)*DW +: DW] <= last_rate_q[i];
				m_data_q[(i+6)*DW +: DW] <= offset_q[i];
			end
			m_stale_q <= ~ok_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_stale_q;

endmodule

`default_nettype wire
